@@ src/fqd_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the fifo queue with delete
// used by fqd_cell and fifo_queue_with_delete_top
package fqd_pkg;

  localparam int DEPTH      = 16;
  localparam int TOKEN_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int TOKO_W     = 32;
  localparam int LEN_W      = 5;
  localparam int IN_W       = ((OP_W + 32 + 7) / 8) * 8;
  localparam int OUT_W      = ((ST_W + TOKO_W + LEN_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } fqd_state_t;

  typedef struct packed {
    logic                  shift;
    logic                  load;
    logic [IDX_W-1:0]      tgt;
    logic [TOKEN_BITS-1:0] wdata;
  } fqd_ctl_t;

endpackage

@@ src/fqd_cell.sv @@
`timescale 1ns / 1ps
// one storage cell of the queue chain: holds one token
// depends on fqd_pkg
module fqd_cell
  import fqd_pkg::*;
(
  input  logic                  clk,
  input  fqd_ctl_t              ctl,
  input  logic [IDX_W-1:0]      cell_idx,
  input  logic [TOKEN_BITS-1:0] nbr_data,
  output logic [TOKEN_BITS-1:0] data
);

  logic [TOKEN_BITS-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.load && (ctl.tgt == cell_idx)) begin
      data_r <= ctl.wdata;
    end else if (ctl.shift) begin
      data_r <= nbr_data;
    end
  end

  assign data = data_r;

endmodule

@@ src/fifo_queue_with_delete_top.sv @@
`timescale 1ns / 1ps
// fifo queue with delete: top level, control and result register
// depends on fqd_pkg and fqd_cell
//
// usage:
//   in_*  channel carries one request: opcode (enqueue, dequeue, delete) and a token.
//   out_* channel returns exactly one result per request: status, dequeued token
//   and the queue length after the request.
//   tokens live in a chain of DEPTH cells; cell 0 is the oldest entry.
// timing:
//   enqueue, dequeue, an unknown opcode, a miss on an empty queue or a null token: result
//   registered in the cycle after the transfer, next request taken in the following cycle.
//   delete: the chain rotates once per cycle through all held entries, dropping
//   the first match, then returns the result with the updated length.
//   one request is in flight at a time.
// reset: length goes to zero, no result pending; cell contents are not cleared.
// stall: a held result stays on out_* until taken; a new request is accepted in
//   the cycle the pending result is taken.
module fifo_queue_with_delete_top
  import fqd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // opcode[1:0], token[33:2], zero fill
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status[1:0], token_out[33:2], length[38:34], zero fill
);

  fqd_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      remain_r, remain_nxt;
  logic                  found_r, found_nxt;
  logic [TOKEN_BITS-1:0] key_r, key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]       out_status_r, out_status_nxt;
  logic [TOKO_W-1:0]     out_tok_r, out_tok_nxt;
  logic [LEN_W-1:0]      out_len_r, out_len_nxt;

  fqd_ctl_t              ctl;
  logic [TOKEN_BITS-1:0] cell_data [DEPTH];
  logic [OP_W-1:0]       in_op;
  logic [TOKEN_BITS-1:0] in_tok;
  logic                  in_fire;
  logic                  drop;

  assign in_op     = in_tdata[OP_W-1:0];
  assign in_tok    = in_tdata[OP_W +: TOKEN_BITS];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign drop      = !found_r && (cell_data[0] == key_r);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [TOKEN_BITS-1:0] nbr;
      if (gi == DEPTH - 1) begin : g_last
        assign nbr = cell_data[gi];
      end else begin : g_mid
        assign nbr = cell_data[gi + 1];
      end
      fqd_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .cell_idx (IDX_W'(gi)),
        .nbr_data (nbr),
        .data     (cell_data[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    found_nxt      = found_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_tok_nxt    = out_tok_r;
    out_len_nxt    = out_len_r;
    ctl.shift      = 1'b0;
    ctl.load       = 1'b0;
    ctl.tgt        = count_r[IDX_W-1:0];
    ctl.wdata      = in_tok;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MISS;
          out_tok_nxt    = '0;
          out_len_nxt    = LEN_W'(count_r);
          case (in_op)
            OP_ENQ: begin
              if (count_r == CNT_W'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctl.load       = 1'b1;
                count_nxt      = count_r + 1'b1;
                out_status_nxt = ST_OK;
                out_len_nxt    = LEN_W'(count_nxt);
              end
            end
            OP_DEQ: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                ctl.shift      = 1'b1;
                count_nxt      = count_r - 1'b1;
                out_status_nxt = ST_OK;
                out_tok_nxt    = TOKO_W'(cell_data[0]);
                out_len_nxt    = LEN_W'(count_nxt);
              end
            end
            OP_DEL: begin
              if ((in_tok != '0) && (count_r != '0)) begin
                out_valid_nxt = 1'b0;
                key_nxt       = in_tok;
                remain_nxt    = count_r;
                found_nxt     = 1'b0;
                state_nxt     = S_SCAN;
              end
            end
            default: begin
              out_status_nxt = ST_MISS;
            end
          endcase
        end
      end
      S_SCAN: begin
        // rotate: head leaves cell 0 and rejoins at the tail unless it is the match
        ctl.shift  = 1'b1;
        ctl.wdata  = cell_data[0];
        ctl.tgt    = IDX_W'(count_r - 1'b1);
        ctl.load   = !drop;
        remain_nxt = remain_r - 1'b1;
        if (drop) begin
          count_nxt = count_r - 1'b1;
          found_nxt = 1'b1;
        end
        if (remain_r == CNT_W'(1)) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = (found_r || drop) ? ST_OK : ST_MISS;
          out_tok_nxt    = '0;
          out_len_nxt    = LEN_W'(count_nxt);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_tok_r    <= out_tok_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - ST_W - TOKO_W - LEN_W)'(0), out_len_r, out_tok_r, out_status_r};

endmodule
